FILE: rtl/core/gbfsa_pkg.sv
// Package for the greedy best-fit slot assigner: item kinds, queue word and state types.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none
package gbfsa_pkg;
   typedef enum logic [1:0] {
      KIND_LOAD_REQ  = 2'd0,
      KIND_LOAD_SLOT = 2'd1,
      KIND_RUN       = 2'd2,
      KIND_NONE      = 2'd3
   } kind_type;

   // word passed from front to back through the queue
   typedef struct packed {
      kind_type    kind;
      logic [15:0] size;
      logic [15:0] price;
      logic [15:0] cap;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_FIT,
      ST_EMIT,
      ST_SUMMARY
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/core/gbfsa_queue.sv
// Short queue between the front (accept/classify) and the back (execute).
// Depends on gbfsa_pkg.
`default_nettype none
module gbfsa_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  gbfsa_pkg::cmd_type  in_cmd,
   output logic                out_valid,
   input  wire                 out_ready,
   output gbfsa_pkg::cmd_type  out_cmd
);
   gbfsa_pkg::cmd_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic       wr, rd;

   assign in_ready  = (cnt_ff != 3'd4);
   assign out_valid = (cnt_ff != 3'd0);
   assign out_cmd   = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= in_cmd;
      end
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr} - {2'd0, rd};
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/gbfsa_front.sv
// Front end: takes input words, drops unknown kinds, forwards the rest to the queue.
// Depends on gbfsa_pkg.
`default_nettype none
module gbfsa_front (
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire  [49:0]         req_word,
   output logic                q_valid,
   input  wire                 q_ready,
   output gbfsa_pkg::cmd_type  q_cmd
);
   gbfsa_pkg::kind_type kind;
   assign kind = gbfsa_pkg::kind_type'(req_word[1:0]);
   assign q_cmd.kind  = kind;
   assign q_cmd.size  = req_word[17:2];
   assign q_cmd.price = req_word[33:18];
   assign q_cmd.cap   = req_word[49:34];
   // unknown kind is swallowed at once
   assign req_ready = (kind == gbfsa_pkg::KIND_NONE) ? 1'b1 : q_ready;
   assign q_valid   = req_valid && (kind != gbfsa_pkg::KIND_NONE);
endmodule
`default_nettype wire

FILE: rtl/core/gbfsa_back.sv
// Back end: stores loads and runs the greedy assignment, one element per cycle.
// Depends on gbfsa_pkg.
`default_nettype none
module gbfsa_back #(
   parameter int MAX_REQUESTS = 32,
   parameter int MAX_SLOTS    = 32,
   parameter int VALUE_BITS   = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   output logic                cmd_ready,
   input  gbfsa_pkg::cmd_type  cmd,
   output logic                out_valid,
   input  wire                 out_ready,
   output logic [39:0]         out_word
);
   localparam int RI = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int SI = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int RC = $clog2(MAX_REQUESTS + 1);
   localparam int SC = $clog2(MAX_SLOTS + 1);

   logic [VALUE_BITS-1:0] size_mem  [MAX_REQUESTS];
   logic [VALUE_BITS-1:0] price_mem [MAX_REQUESTS];
   logic [VALUE_BITS-1:0] cap_mem   [MAX_SLOTS];
   logic [MAX_REQUESTS-1:0] done_ff;
   logic [MAX_SLOTS-1:0]    taken_ff;
   logic [RC-1:0] rcnt_ff;
   logic [SC-1:0] scnt_ff;
   logic          ovf_ff;

   gbfsa_pkg::state_type st_ff, st_in;
   logic [RC-1:0] i_ff, round_ff;
   logic [SC-1:0] j_ff;
   logic          have_ff, fit_ff;
   logic [RI-1:0] pick_ff;
   logic [SI-1:0] best_ff;
   logic [VALUE_BITS-1:0] pprice_ff, psize_ff, bcap_ff;
   logic [5:0]  placed_ff;
   logic [20:0] total_ff;
   logic        ovr_ff;
   logic        out_v_ff;
   logic [39:0] out_w_ff;

   // registered read data and the index/valid of the element it belongs to
   logic [VALUE_BITS-1:0] pr_q_ff, sz_q_ff, cp_q_ff;
   logic [RI-1:0] pidx_ff;
   logic [SI-1:0] jidx_ff;
   logic          pv_ff, jv_ff;

   logic [RI-1:0] ia;
   logic [SI-1:0] ja;
   logic take_i, fit_j, out_free, emit_go;
   assign ia = i_ff[RI-1:0];
   assign ja = j_ff[SI-1:0];
   assign take_i = pv_ff && !done_ff[pidx_ff] && (!have_ff || pr_q_ff > pprice_ff);
   assign fit_j  = jv_ff && !taken_ff[jidx_ff] && cp_q_ff >= psize_ff
                   && (!fit_ff || cp_q_ff < bcap_ff);
   assign out_free = !out_v_ff || out_ready;
   assign emit_go  = out_free
                     && (st_ff == gbfsa_pkg::ST_EMIT || st_ff == gbfsa_pkg::ST_SUMMARY);
   assign out_valid = out_v_ff;
   assign out_word  = out_w_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         gbfsa_pkg::ST_IDLE:
            if (cmd_valid && cmd.kind == gbfsa_pkg::KIND_RUN) st_in = gbfsa_pkg::ST_PICK;
         gbfsa_pkg::ST_PICK:
            if (round_ff == rcnt_ff) st_in = gbfsa_pkg::ST_SUMMARY;
            else if (i_ff == rcnt_ff && !pv_ff) st_in = gbfsa_pkg::ST_FIT;
         gbfsa_pkg::ST_FIT:
            if (j_ff == scnt_ff && !jv_ff)
               st_in = fit_ff ? gbfsa_pkg::ST_EMIT : gbfsa_pkg::ST_PICK;
         gbfsa_pkg::ST_EMIT:
            if (out_free) st_in = gbfsa_pkg::ST_PICK;
         gbfsa_pkg::ST_SUMMARY:
            if (out_free) st_in = gbfsa_pkg::ST_IDLE;
         default: st_in = gbfsa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_ready = (st_ff == gbfsa_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      pr_q_ff <= price_mem[ia];
      sz_q_ff <= size_mem[ia];
      cp_q_ff <= cap_mem[ja];
      pidx_ff <= ia;
      jidx_ff <= ja;
      if (st_ff == gbfsa_pkg::ST_IDLE && cmd_valid) begin
         if (cmd.kind == gbfsa_pkg::KIND_LOAD_REQ && rcnt_ff < RC'(MAX_REQUESTS)) begin
            size_mem[rcnt_ff[RI-1:0]]  <= VALUE_BITS'(cmd.size);
            price_mem[rcnt_ff[RI-1:0]] <= VALUE_BITS'(cmd.price);
         end
         if (cmd.kind == gbfsa_pkg::KIND_LOAD_SLOT && scnt_ff < SC'(MAX_SLOTS))
            cap_mem[scnt_ff[SI-1:0]] <= VALUE_BITS'(cmd.cap);
      end
      if (reset) begin
         st_ff <= gbfsa_pkg::ST_IDLE;
         rcnt_ff <= '0; scnt_ff <= '0; ovf_ff <= 1'b0; out_v_ff <= 1'b0;
         pv_ff <= 1'b0; jv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pv_ff <= (st_ff == gbfsa_pkg::ST_PICK) && (round_ff != rcnt_ff) && (i_ff != rcnt_ff);
         jv_ff <= (st_ff == gbfsa_pkg::ST_FIT) && (j_ff != scnt_ff);
         if (emit_go) out_v_ff <= 1'b1;
         else if (out_ready) out_v_ff <= 1'b0;
         case (st_ff)
            gbfsa_pkg::ST_IDLE: if (cmd_valid) begin
               case (cmd.kind)
                  gbfsa_pkg::KIND_LOAD_REQ:
                     if (rcnt_ff < RC'(MAX_REQUESTS)) rcnt_ff <= rcnt_ff + RC'(1);
                     else ovf_ff <= 1'b1;
                  gbfsa_pkg::KIND_LOAD_SLOT:
                     if (scnt_ff < SC'(MAX_SLOTS)) scnt_ff <= scnt_ff + SC'(1);
                     else ovf_ff <= 1'b1;
                  gbfsa_pkg::KIND_RUN: begin
                     done_ff <= '0; taken_ff <= '0; round_ff <= '0; i_ff <= '0;
                     have_ff <= 1'b0; placed_ff <= '0; total_ff <= '0;
                     ovr_ff <= ovf_ff;
                  end
                  default: ;
               endcase
            end
            gbfsa_pkg::ST_PICK: if (round_ff != rcnt_ff) begin
               if (take_i) begin
                  have_ff <= 1'b1; pick_ff <= pidx_ff;
                  pprice_ff <= pr_q_ff; psize_ff <= sz_q_ff;
               end
               if (i_ff != rcnt_ff) begin
                  i_ff <= i_ff + RC'(1);
               end else if (!pv_ff) begin
                  done_ff[pick_ff] <= 1'b1;
                  round_ff <= round_ff + RC'(1);
                  j_ff <= '0; fit_ff <= 1'b0;
               end
            end
            gbfsa_pkg::ST_FIT: begin
               if (fit_j) begin
                  fit_ff <= 1'b1; best_ff <= jidx_ff; bcap_ff <= cp_q_ff;
               end
               if (j_ff != scnt_ff) begin
                  j_ff <= j_ff + SC'(1);
               end else if (!jv_ff) begin
                  i_ff <= '0; have_ff <= 1'b0;
               end
            end
            gbfsa_pkg::ST_EMIT: if (out_free) begin
               taken_ff[best_ff] <= 1'b1;
               placed_ff <= placed_ff + 6'd1;
               total_ff  <= total_ff + 21'(pprice_ff);
               out_w_ff  <= {1'b0, ovr_ff, 21'd0, 6'd0, 5'(best_ff), 5'(pick_ff), 1'b0};
            end
            gbfsa_pkg::ST_SUMMARY: if (out_free) begin
               out_w_ff <= {1'b1, ovr_ff, total_ff, placed_ff, 5'd0, 5'd0, 1'b1};
               rcnt_ff <= '0; scnt_ff <= '0; ovf_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/greedy_best_fit_slot_assigner.sv
// Top level of the greedy best-fit slot assigner: front, queue and back joined.
// Depends on gbfsa_pkg, gbfsa_front, gbfsa_queue, gbfsa_back.
//
// channel | dir | ports           | contents
// req     | in  | req_t*          | load request, load slot, run (kind in tuser)
// rsp     | out | rsp_t*          | placement pairs, then summary (last)
//
// A run takes one round per loaded request (R requests, S slots): each
// round does a pick scan over the R requests and a fit scan over the S
// slots (registered reads, one element per cycle), plus an emit step
// when a placement is found.
// Reset is synchronous; it clears counts, flags and the queue.
// The four-deep queue takes words while the back works; the output
// register holds a result while rsp_tready is low.
`default_nettype none
module greedy_best_fit_slot_assigner #(
   parameter int MAX_REQUESTS = 32,
   parameter int MAX_SLOTS    = 32,
   parameter int VALUE_BITS   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // request_size[15:0], request_price[31:16], slot_capacity[47:32]
   input  wire  [47:0] req_tdata,
   // req_type[1:0]
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // placed_request[4:0], given_slot[9:5], placed_count[15:10],
   // total_price[36:16], overflow[37]
   output logic [39:0] rsp_tdata,
   // is_summary
   output logic        rsp_tuser,
   output logic        rsp_tlast
);
   logic               fq_valid, fq_ready, qb_valid, qb_ready;
   gbfsa_pkg::cmd_type fq_cmd, qb_cmd;
   logic [39:0]        word;

   gbfsa_front u_front (
      .req_valid(req_tvalid), .req_ready(req_tready), .req_word({req_tdata, req_tuser}),
      .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
   );

   gbfsa_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_cmd(fq_cmd),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_cmd(qb_cmd)
   );

   gbfsa_back #(
      .MAX_REQUESTS(MAX_REQUESTS), .MAX_SLOTS(MAX_SLOTS), .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_word(word)
   );

   // word layout: [0] is_summary, [5:1] req, [10:6] slot, [16:11] count,
   // [37:17] total, [38] overflow, [39] last
   assign rsp_tuser = word[0];
   assign rsp_tdata = {2'd0, word[38:1]};
   assign rsp_tlast = word[39];
endmodule
`default_nettype wire
